// ===== hw/rtl/mkdb_pkg.sv =====
// Shared types and constants for the multi-key debounce block.
`default_nettype none

package mkdb_pkg;

	// Beat kinds on the input channel
	localparam logic KIND_SCAN  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Per-key phase codes
	localparam logic [1:0] PH_IDLE       = 2'd0;
	localparam logic [1:0] PH_PRESS_DB   = 2'd1;
	localparam logic [1:0] PH_HELD       = 2'd2;
	localparam logic [1:0] PH_RELEASE_DB = 2'd3;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned DB_W       = 16;
	localparam int unsigned PIN_W      = 3;
	localparam int unsigned QKEY_W     = 3;
	localparam int unsigned EVT_OUT_W  = 3;

	localparam logic [DB_W-1:0] DEBOUNCE_RESET = 16'd20;

	// Scan step broadcast to every key slice
	typedef struct packed {
		logic              fire;
		logic [TIME_W-1:0] now_ms;
		logic [DB_W-1:0]   debounce_ms;
	} mkdb_scan_t;

endpackage : mkdb_pkg

`default_nettype wire

// ===== hw/rtl/multi_key_debounce_short_press.sv =====
// Top level: input register, key slices, event bitmap and result register.
//
// Usage: beats arrive on the input channel (in_valid/in_ready). A scan beat
// (kind = 0) carries now_ms and the active-low pin levels; every key's phase
// machine steps once. A query beat (kind = 1) reads and clears the event bit
// of query_key; an index at or above NUM_KEYS reads 0 and changes nothing.
// Each input beat gives exactly one result beat (hit, event_bits) on the
// output channel (out_valid/out_ready).
// Timing: the result passes through the input register and then the result
// register before out_valid rises. Throughput: one beat per cycle while the
// receiver does not stall, set by the single pass of per-key compare and
// update logic between the two registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; after that in_ready drops until the
// result is taken.
// debounce_ms is written through cfg_valid/cfg_data (cfg_ready is always
// high); the user must write it only while idle, the block does not enforce it.
// Reset: all keys idle, event bitmap clear, debounce_ms = 20, both pipeline
// registers empty.
`default_nettype none

module multi_key_debounce_short_press
	import mkdb_pkg::*;
#(
	parameter int unsigned NUM_KEYS = 3
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input channel
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 kind,
	input  wire logic [TIME_W-1:0]    now_ms,
	input  wire logic [PIN_W-1:0]     pin_levels,
	input  wire logic [QKEY_W-1:0]    query_key,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      hit,
	output logic [EVT_OUT_W-1:0]      event_bits,
	// configuration channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [DB_W-1:0]      cfg_data
);

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [DB_W-1:0] debounce_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			debounce_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------
	// Input register (stage 1)
	// ---------------------------------------------------------------
	logic              valid_s1;
	logic              kind_s1;
	logic [TIME_W-1:0] now_s1;
	logic [PIN_W-1:0]  pins_s1;
	logic [QKEY_W-1:0] query_s1;

	logic advance;   // result register free to load this cycle
	logic step;      // the stage 1 beat is processed this cycle

	assign advance  = !out_valid || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			now_s1   <= now_ms;
			pins_s1  <= pin_levels;
			query_s1 <= query_key;
		end
	end

	// ---------------------------------------------------------------
	// Key slices: all keys step together on a scan beat
	// ---------------------------------------------------------------
	mkdb_scan_t          scan;
	logic [NUM_KEYS-1:0] set_vec;
	logic [NUM_KEYS-1:0] qmask;

	assign scan.fire        = step && (kind_s1 == KIND_SCAN);
	assign scan.now_ms      = now_s1;
	assign scan.debounce_ms = debounce_q;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		logic down;
		// keys beyond the pin field always read as pressed
		if (k < PIN_W) begin : g_pin
			assign down = !pins_s1[k];
		end else begin : g_nopin
			assign down = 1'b1;
		end

		mkdb_key u_key (
			.clk     (clk),
			.arst_n  (arst_n),
			.scan    (scan),
			.down    (down),
			.set_evt (set_vec[k])
		);

		// one-hot query decode; an index out of range selects nothing
		assign qmask[k] = (query_s1 == QKEY_W'(k));
	end

	// ---------------------------------------------------------------
	// Event bitmap and result register (stage 2)
	// ---------------------------------------------------------------
	logic [NUM_KEYS-1:0]  evt_q;
	logic [NUM_KEYS-1:0]  evt_d;
	logic                 hit_d;
	logic [EVT_OUT_W-1:0] evt_out_d;
	logic                 out_valid_q;
	logic                 hit_q;
	logic [EVT_OUT_W-1:0] event_bits_q;

	always_comb begin
		evt_d = evt_q;
		hit_d = 1'b0;
		if (kind_s1 == KIND_SCAN) begin
			evt_d = evt_q | set_vec;
		end else begin
			hit_d = |(evt_q & qmask);
			evt_d = evt_q & ~qmask;
		end
	end

	// only the low bits of the bitmap leave the block
	for (genvar b = 0; b < EVT_OUT_W; b++) begin : g_out
		if (b < NUM_KEYS) begin : g_live
			assign evt_out_d[b] = evt_d[b];
		end else begin : g_zero
			assign evt_out_d[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				evt_q <= evt_d;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			hit_q        <= hit_d;
			event_bits_q <= evt_out_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign event_bits = event_bits_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_scan_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(step && kind_s1 == KIND_SCAN) |=> !hit_q)
		else $error("scan beat produced a hit");

	a_query_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && kind_s1 == KIND_QUERY) |=> ((evt_q & $past(qmask)) == '0))
		else $error("queried event bit not cleared");

	a_set_only_on_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && kind_s1 == KIND_SCAN) |=> ((evt_q & ~$past(evt_q)) == '0))
		else $error("event bit set outside a scan beat");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input register would be overwritten while stalled");

endmodule : multi_key_debounce_short_press

`default_nettype wire

// ===== hw/rtl/mkdb_key.sv =====
// One key's debounce phase machine and time mark.
`default_nettype none

module mkdb_key
	import mkdb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire mkdb_scan_t scan,
	input  wire logic       down,
	output logic            set_evt
);

	logic [1:0]        phase_q;
	logic [1:0]        phase_d;
	logic [TIME_W-1:0] mark_q;
	logic              mark_load;
	logic [TIME_W-1:0] elapsed;
	logic [DB_W-2:0]   half;
	logic              full_ok;
	logic              half_ok;
	logic              set_d;

	// Elapsed time wraps modulo 2^32
	assign elapsed = scan.now_ms - mark_q;
	assign half    = scan.debounce_ms[DB_W-1:1];
	assign full_ok = elapsed >= {{(TIME_W-DB_W){1'b0}}, scan.debounce_ms};
	assign half_ok = elapsed >= {{(TIME_W-DB_W+1){1'b0}}, half};

	always_comb begin
		phase_d   = phase_q;
		mark_load = 1'b0;
		set_d     = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (down) begin
					phase_d   = PH_PRESS_DB;
					mark_load = 1'b1;
				end
			end
			PH_PRESS_DB: begin
				if (down) begin
					if (full_ok) phase_d = PH_HELD;
				end else begin
					// released early but past half time still counts
					set_d   = half_ok;
					phase_d = PH_IDLE;
				end
			end
			PH_HELD: begin
				if (!down) begin
					phase_d   = PH_RELEASE_DB;
					mark_load = 1'b1;
				end
			end
			PH_RELEASE_DB: begin
				if (!down) begin
					if (full_ok) begin
						set_d   = 1'b1;
						phase_d = PH_IDLE;
					end
				end else if (!half_ok) begin
					phase_d = PH_HELD;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	assign set_evt = scan.fire & set_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (scan.fire) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.fire && mark_load) begin
			mark_q <= scan.now_ms;
		end
	end

endmodule : mkdb_key

`default_nettype wire
